/* rtl/moss_pkg.sv */
// Shared types and constants for the macro operation stream scanner.
// Holds phase codes, operand kinds, the operand table and the item/result structs.
// No dependencies.
package moss_pkg;

    localparam int ByteWidth   = 8;
    localparam int ResultWidth = 32;
    localparam int StatusWidth = 2;
    localparam int MDataWidth  = 72;

    localparam logic [2:0] PH_OPCODE  = 3'd0;
    localparam logic [2:0] PH_ULEB    = 3'd1;
    localparam logic [2:0] PH_STRING  = 3'd2;
    localparam logic [2:0] PH_FIXED   = 3'd3;
    localparam logic [2:0] PH_DISCARD = 3'd4;

    localparam logic [1:0] K_NONE = 2'd0;
    localparam logic [1:0] K_ULEB = 2'd1;
    localparam logic [1:0] K_STR  = 2'd2;
    localparam logic [1:0] K_OFF  = 2'd3;

    localparam logic [1:0] ST_CLEAN     = 2'd0;
    localparam logic [1:0] ST_UNHANDLED = 2'd1;
    localparam logic [1:0] ST_PAST_END  = 2'd2;

    localparam logic [7:0] LAST_STD_OP = 8'd12;
    localparam logic [3:0] OFF_LEN_32  = 4'd4;
    localparam logic [3:0] OFF_LEN_64  = 4'd8;

    typedef struct packed {
        logic [ByteWidth-1:0] byte_value;
        logic                 last_byte;
    } moss_item_t;

    typedef struct packed {
        logic                   emit;
        logic [StatusWidth-1:0] status;
        logic [ResultWidth-1:0] op_count;
        logic [ResultWidth-1:0] unit_length;
    } moss_result_t;

    // Operand kind of operand idx (0 or 1) of standard opcode op.
    function automatic logic [1:0] operand_kind(input logic [3:0] op, input logic idx);
        logic [1:0] k;
        unique case (op)
            4'd1, 4'd2:         k = idx ? K_STR  : K_ULEB;
            4'd3, 4'd11, 4'd12: k = K_ULEB;
            4'd5, 4'd6,
            4'd8, 4'd9:         k = idx ? K_OFF  : K_ULEB;
            4'd7, 4'd10:        k = idx ? K_NONE : K_OFF;
            default:            k = K_NONE;
        endcase
        return k;
    endfunction

endpackage

/* rtl/macro_op_stream_scanner_unit.sv */
// A result enters the result register at the rising edge at which its byte leaves the
// input register; that edge waits while a held result is not yet taken.
// Throughput: one byte per cycle, set by the scan state update between the
// input register and the result register; stalls only while a result waits on m_tready.
// Reset (aresetn low, synchronous) empties both registers, returns the scanner to
// expecting an opcode with zeroed counters, and selects 4-byte offsets.
// Top level; depends on moss_pkg, moss_in_reg, moss_scan_core and moss_out_reg.
module macro_op_stream_scanner_unit #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,    // offset_size_64
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // byte_value
    input  logic        s_tlast,        // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [moss_pkg::MDataWidth-1:0] m_tdata // status, op_count, unit_length, zero pad
);
    import moss_pkg::*;

    logic         item_valid;
    moss_item_t   item;
    moss_result_t result;
    logic         out_busy;
    logic         advance;

    assign advance = item_valid && !out_busy;

    moss_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    moss_scan_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_scan_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step_en     (advance),
        .item        (item),
        .result      (result)
    );

    moss_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && result.emit),
        .result   (result),
        .busy     (out_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* rtl/moss_in_reg.sv */
// Input register of the scanner: captures one byte transaction from the slave side.
// Depends on moss_pkg.
module moss_in_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tlast,
    input  logic                advance,
    output logic                item_valid,
    output moss_pkg::moss_item_t item
);
    import moss_pkg::*;

    logic       valid_reg, valid_next;
    moss_item_t item_reg;
    logic       load;

    assign s_tready   = !valid_reg || advance;
    assign load       = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg.byte_value <= s_tdata;
            item_reg.last_byte  <= s_tlast;
        end
    end

endmodule

/* rtl/moss_scan_core.sv */
// Scan state machine and saturating counters: decides per byte where operations end.
// Depends on moss_pkg.
module moss_scan_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic                  step_en,
    input  moss_pkg::moss_item_t  item,
    output moss_pkg::moss_result_t result
);
    import moss_pkg::*;

    logic                   off64_reg, off64_next;
    logic [2:0]             phase_reg, phase_next;
    logic [3:0]             opcode_reg, opcode_next;
    logic [1:0]             idx_reg, idx_next;
    logic [3:0]             fixed_reg, fixed_next;
    logic [COUNT_WIDTH-1:0] op_cnt_reg, op_cnt_next;
    logic [COUNT_WIDTH-1:0] byte_cnt_reg, byte_cnt_next;

    logic [COUNT_WIDTH-1:0] op_inc, byte_inc, op_sel;
    logic [ResultWidth-1:0] op_clip, byte_clip;
    logic                   begin_op;
    logic [2:0]             begin_idx;
    logic [3:0]             kind_opcode;
    logic [1:0]             kind;
    logic [7:0]             b;
    logic                   emit;
    logic [1:0]             status;

    assign b        = item.byte_value;
    assign op_inc   = (op_cnt_reg == '1) ? op_cnt_reg : op_cnt_reg + 1'b1;
    assign byte_inc = (byte_cnt_reg == '1) ? byte_cnt_reg : byte_cnt_reg + 1'b1;
    assign op_sel   = (phase_reg == PH_OPCODE) ? op_inc : op_cnt_reg;

    generate
        if (COUNT_WIDTH > ResultWidth) begin : g_clip
            assign op_clip   = (|op_sel[COUNT_WIDTH-1:ResultWidth]) ? '1
                                                                   : op_sel[ResultWidth-1:0];
            assign byte_clip = (|byte_inc[COUNT_WIDTH-1:ResultWidth]) ? '1
                                                                     : byte_inc[ResultWidth-1:0];
        end else begin : g_ext
            assign op_clip   = ResultWidth'(op_sel);
            assign byte_clip = ResultWidth'(byte_inc);
        end
    endgenerate

    assign begin_idx   = (phase_reg == PH_OPCODE) ? 3'd0 : {1'b0, idx_reg} + 3'd1;
    assign kind_opcode = (phase_reg == PH_OPCODE) ? b[3:0] : opcode_reg;
    assign kind = (begin_idx < 3'd2) ? operand_kind(kind_opcode, begin_idx[0]) : K_NONE;

    always_comb begin
        off64_next    = cfg_wr_en ? cfg_wr_data : off64_reg;
        phase_next    = phase_reg;
        opcode_next   = opcode_reg;
        idx_next      = idx_reg;
        fixed_next    = fixed_reg;
        op_cnt_next   = op_cnt_reg;
        byte_cnt_next = byte_cnt_reg;
        begin_op      = 1'b0;
        emit          = 1'b0;
        status        = ST_CLEAN;
        if (step_en) begin
            if (phase_reg == PH_DISCARD) begin
                if (item.last_byte) begin
                    phase_next = PH_OPCODE;
                end
            end else if (phase_reg > PH_FIXED) begin
                phase_next = PH_OPCODE;
            end else begin
                byte_cnt_next = byte_inc;
                unique case (phase_reg)
                    PH_OPCODE: begin
                        op_cnt_next = op_inc;
                        if (b == 8'd0) begin
                            emit   = 1'b1;
                            status = ST_CLEAN;
                        end else if (b > LAST_STD_OP) begin
                            emit       = 1'b1;
                            status     = ST_UNHANDLED;
                            phase_next = item.last_byte ? PH_OPCODE : PH_DISCARD;
                        end else begin
                            opcode_next = b[3:0];
                            begin_op    = 1'b1;
                        end
                    end
                    PH_ULEB: begin
                        begin_op = !b[7];
                    end
                    PH_STRING: begin
                        begin_op = (b == 8'd0);
                    end
                    default: begin
                        if (fixed_reg <= 4'd1) begin
                            fixed_next = 4'd0;
                            begin_op   = 1'b1;
                        end else begin
                            fixed_next = fixed_reg - 4'd1;
                        end
                    end
                endcase
                if (begin_op) begin
                    idx_next = begin_idx[1:0];
                    unique case (kind)
                        K_ULEB: phase_next = PH_ULEB;
                        K_STR:  phase_next = PH_STRING;
                        K_OFF: begin
                            phase_next = PH_FIXED;
                            fixed_next = off64_reg ? OFF_LEN_64 : OFF_LEN_32;
                        end
                        default: begin
                            phase_next = PH_OPCODE;
                            idx_next   = 2'd0;
                        end
                    endcase
                end
                if (item.last_byte && !emit) begin
                    phase_next = PH_OPCODE;
                    idx_next   = 2'd0;
                    fixed_next = 4'd0;
                    emit       = 1'b1;
                    status     = ST_PAST_END;
                end
                if (emit) begin
                    op_cnt_next   = '0;
                    byte_cnt_next = '0;
                end
            end
        end
    end

    assign result.emit        = emit;
    assign result.status      = status;
    assign result.op_count    = op_clip;
    assign result.unit_length = byte_clip;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off64_reg    <= 1'b0;
            phase_reg    <= PH_OPCODE;
            opcode_reg   <= 4'd0;
            idx_reg      <= 2'd0;
            fixed_reg    <= 4'd0;
            op_cnt_reg   <= '0;
            byte_cnt_reg <= '0;
        end else begin
            off64_reg    <= off64_next;
            phase_reg    <= phase_next;
            opcode_reg   <= opcode_next;
            idx_reg      <= idx_next;
            fixed_reg    <= fixed_next;
            op_cnt_reg   <= op_cnt_next;
            byte_cnt_reg <= byte_cnt_next;
        end
    end

endmodule

/* rtl/moss_out_reg.sv */
// Result register of the scanner: holds one result transaction for the master side.
// Depends on moss_pkg.
module moss_out_reg (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  moss_pkg::moss_result_t result,
    output logic                   busy,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [moss_pkg::MDataWidth-1:0] m_tdata
);
    import moss_pkg::*;

    logic                   valid_reg, valid_next;
    logic [StatusWidth-1:0] status_reg;
    logic [ResultWidth-1:0] op_count_reg;
    logic [ResultWidth-1:0] unit_length_reg;

    assign busy     = valid_reg && !m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(MDataWidth - StatusWidth - 2 * ResultWidth){1'b0}},
                       unit_length_reg, op_count_reg, status_reg};

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg      <= result.status;
            op_count_reg    <= result.op_count;
            unit_length_reg <= result.unit_length;
        end
    end

endmodule
